[rtl/dhd_pkg.sv]
// Shared types, constants and the hash multiply for the dual-hash dedup filter.
// No dependencies; every other file in rtl imports this package.
package dhd_pkg;

   localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
   localparam logic [63:0] ALT_BASIS = 64'd1099511628211;
   localparam int          FOLD_SHIFT = 32;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic clear;
      logic capture;
      logic mix;
      logic fold;
      logic scan_read;
      logic scan_cmp;
      logic finish;
   } dhd_cmd_type;

   typedef struct packed {
      logic record_last;
      logic table_ok;
      logic scan_last;
   } dhd_status_type;

   // The FNV-1a 64 prime is 2^40 + 0x1B3, so the product is a short sum of shifts.
   function automatic logic [63:0] mul_prime(input logic [63:0] x);
      mul_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

[rtl/dual_hash_dedup_filter.sv]
// Top level of the dual-hash dedup filter: controller plus datapath.
// Depends on dhd_pkg, dhd_ctrl and dhd_datapath.
//
// Each byte beat is accepted, multiplied and folded in turn; busy is high
// while it is multiplied and folded. For a select below TABLES, a record's
// last byte then scans its table slot by slot (read, compare) through the
// single read port of the slot memory and stores a miss. A clear beat keeps
// busy low. Results appear for one cycle with rsp_valid and cannot be stalled.
module dual_hash_dedup_filter
   import dhd_pkg::*;
#(
   parameter int SLOTS  = 16,
   parameter int TABLES = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_field_start,
   input  logic        req_record_last,
   input  logic [2:0]  req_table_select,
   output logic        rsp_valid,
   output logic        rsp_emit,
   output logic        rsp_evicted,
   output logic [31:0] rsp_duplicate_count,
   output logic [31:0] rsp_replacement_count
);

   dhd_cmd_type    cmd;
   dhd_status_type status;

   dhd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   dhd_datapath #(
      .SLOTS  (SLOTS),
      .TABLES (TABLES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_data_byte         (req_data_byte),
      .req_field_start       (req_field_start),
      .req_record_last       (req_record_last),
      .req_table_select      (req_table_select),
      .rsp_valid             (rsp_valid),
      .rsp_emit              (rsp_emit),
      .rsp_evicted           (rsp_evicted),
      .rsp_duplicate_count   (rsp_duplicate_count),
      .rsp_replacement_count (rsp_replacement_count)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_dup_not_evicted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_emit |-> !rsp_evicted) else $error("duplicate marked evicted");
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");

endmodule

[rtl/dhd_ctrl.sv]
// Sequencing state machine of the dual-hash dedup filter.
// Depends on dhd_pkg for the command and status structs.
module dhd_ctrl
   import dhd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           req_command,
   input  dhd_status_type status,
   output dhd_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_FOLD,
      ST_READ,
      ST_CMP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = (status.record_last && status.table_ok) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = status.scan_last ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/dhd_datapath.sv]
// Hash registers, slot memory, valid bits and counters of the dedup filter.
// Depends on dhd_pkg; driven by dhd_ctrl commands.
module dhd_datapath
   import dhd_pkg::*;
#(
   parameter int SLOTS  = 16,
   parameter int TABLES = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  dhd_cmd_type    cmd,
   output dhd_status_type status,
   input  logic [7:0]     req_data_byte,
   input  logic           req_field_start,
   input  logic           req_record_last,
   input  logic [2:0]     req_table_select,
   output logic           rsp_valid,
   output logic           rsp_emit,
   output logic           rsp_evicted,
   output logic [31:0]    rsp_duplicate_count,
   output logic [31:0]    rsp_replacement_count
);

   localparam int DEPTH  = TABLES * SLOTS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TSEL_W = (TABLES > 1) ? $clog2(TABLES) : 1;

   logic [127:0]       mem [DEPTH];
   logic [127:0]       mem_q_ff;
   logic [DEPTH-1:0]   valid_ff;
   logic [IDX_W-1:0]   ptr_ff [TABLES];
   logic [31:0]        dup_ff [TABLES];
   logic [31:0]        rep_ff [TABLES];

   logic [63:0]        h1_ff, h2_ff, p1_ff, p2_ff;
   logic [7:0]         pos_ff, byte_ff;
   logic               fstart_ff, last_ff;
   logic [2:0]         sel_ff;
   logic [IDX_W-1:0]   idx_ff, free_idx_ff;
   logic               hit_ff, free_found_ff;

   logic [7:0]         pos_eff;
   logic [TSEL_W-1:0]  tsel;
   logic [ADDR_W-1:0]  scan_addr, write_addr;
   logic [IDX_W-1:0]   write_idx;
   logic [31:0]        dup_in, rep_in;
   logic               valid_bit, match;

   assign pos_eff    = fstart_ff ? 8'd0 : pos_ff;
   assign tsel       = TSEL_W'(sel_ff);
   assign scan_addr  = ADDR_W'(32'(sel_ff) * SLOTS + 32'(idx_ff));
   assign write_idx  = free_found_ff ? free_idx_ff : ptr_ff[tsel];
   assign write_addr = ADDR_W'(32'(sel_ff) * SLOTS + 32'(write_idx));
   assign valid_bit  = valid_ff[scan_addr];
   assign match      = (mem_q_ff == {h1_ff, h2_ff});
   assign dup_in     = hit_ff ? sat_inc(dup_ff[tsel]) : dup_ff[tsel];
   assign rep_in     = (!hit_ff && !free_found_ff) ? sat_inc(rep_ff[tsel]) : rep_ff[tsel];

   assign status.record_last = last_ff;
   assign status.table_ok    = (32'(sel_ff) < TABLES);
   assign status.scan_last   = (idx_ff == IDX_W'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         mem_q_ff <= mem[scan_addr];
      end
      if (cmd.finish && !hit_ff) begin
         mem[write_addr] <= {h1_ff, h2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff   <= req_data_byte;
         fstart_ff <= req_field_start;
         last_ff   <= req_record_last;
         sel_ff    <= req_table_select;
      end
      if (cmd.mix) begin
         p1_ff <= mul_prime(h1_ff ^ {56'd0, byte_ff});
         p2_ff <= mul_prime(h2_ff ^ {56'd0, byte_ff + pos_eff});
      end
      if (cmd.fold) begin
         idx_ff        <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (cmd.scan_cmp) begin
         if (valid_bit && match) begin
            hit_ff <= 1'b1;
         end
         if (!valid_bit && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.finish) begin
         rsp_emit              <= !hit_ff;
         rsp_evicted           <= !hit_ff && !free_found_ff;
         rsp_duplicate_count   <= dup_in;
         rsp_replacement_count <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff  <= '0;
         h1_ff     <= FNV_BASIS;
         h2_ff     <= ALT_BASIS;
         pos_ff    <= 8'd0;
         rsp_valid <= 1'b0;
         for (int t = 0; t < TABLES; t++) begin
            ptr_ff[t] <= '0;
            dup_ff[t] <= '0;
            rep_ff[t] <= '0;
         end
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.mix) begin
            pos_ff <= pos_eff + 8'd1;
         end
         if (cmd.fold) begin
            if (last_ff && !status.table_ok) begin
               h1_ff  <= FNV_BASIS;
               h2_ff  <= ALT_BASIS;
               pos_ff <= 8'd0;
            end else begin
               h1_ff <= p1_ff;
               h2_ff <= p2_ff ^ (p2_ff >> FOLD_SHIFT);
            end
         end
         if (cmd.finish) begin
            h1_ff        <= FNV_BASIS;
            h2_ff        <= ALT_BASIS;
            pos_ff       <= 8'd0;
            dup_ff[tsel] <= dup_in;
            rep_ff[tsel] <= rep_in;
            if (!hit_ff) begin
               valid_ff[write_addr] <= 1'b1;
               if (!free_found_ff) begin
                  ptr_ff[tsel] <= (ptr_ff[tsel] == IDX_W'(SLOTS - 1)) ?
                                  '0 : ptr_ff[tsel] + IDX_W'(1);
               end
            end
         end
      end
   end

endmodule

[test/tb_top.sv]
// Self-checking testbench for dual_hash_dedup_filter: drives byte beats and clears,
// predicts each lookup result from its own table model and compares them.
// Depends on dhd_pkg and the RTL top level.
module tb_top;
   import dhd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS  = 16;
   localparam int TABLES = 6;
   localparam logic CMD_HASH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;
   localparam logic [63:0] PRIME = 64'd1099511628211;

   typedef struct packed {
      logic        emit;
      logic        evicted;
      logic [31:0] dup;
      logic [31:0] repl;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        req_field_start = 1'b0;
   logic        req_record_last = 1'b0;
   logic [2:0]  req_table_select = '0;
   logic        rsp_valid;
   logic        rsp_emit;
   logic        rsp_evicted;
   logic [31:0] rsp_duplicate_count;
   logic [31:0] rsp_replacement_count;

   dual_hash_dedup_filter #(.SLOTS(SLOTS), .TABLES(TABLES)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic        tab_valid [TABLES][SLOTS];
   logic [63:0] tab_h1 [TABLES][SLOTS];
   logic [63:0] tab_h2 [TABLES][SLOTS];
   logic [3:0]  tab_ptr [TABLES];
   logic [31:0] tab_dup [TABLES];
   logic [31:0] tab_repl [TABLES];
   logic [63:0] run_h1, run_h2;
   logic [7:0]  run_pos;
   verdict_type verdict_q[$];
   int          errors = 0;
   bit          idle_on = 1'b1;

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic clear_model();
      for (int t = 0; t < TABLES; t++) begin
         for (int s = 0; s < SLOTS; s++) begin
            tab_valid[t][s] = 1'b0;
            tab_h1[t][s] = '0;
            tab_h2[t][s] = '0;
         end
         tab_ptr[t] = '0;
         tab_dup[t] = '0;
         tab_repl[t] = '0;
      end
      run_h1 = 64'd1469598103934665603;
      run_h2 = 64'd1099511628211;
      run_pos = '0;
   endtask

   task automatic predict_beat(logic cmd, logic [7:0] b, logic fs, logic last, logic [2:0] sel);
      verdict_type v;
      logic [7:0] mixed;
      int hit;
      int free_slot;
      if (cmd == CMD_CLEAR) begin
         clear_model();
         return;
      end
      if (fs) run_pos = '0;
      run_h1 = (run_h1 ^ {56'd0, b}) * PRIME;
      mixed = b + run_pos;
      run_h2 = (run_h2 ^ {56'd0, mixed}) * PRIME;
      run_h2 = run_h2 ^ (run_h2 >> 32);
      run_pos = run_pos + 8'd1;
      if (!last) return;
      if (sel < TABLES) begin
         hit = -1;
         free_slot = -1;
         for (int s = 0; s < SLOTS; s++) begin
            if (hit < 0 && tab_valid[sel][s] && tab_h1[sel][s] == run_h1 &&
                tab_h2[sel][s] == run_h2) hit = s;
            if (free_slot < 0 && !tab_valid[sel][s]) free_slot = s;
         end
         v.evicted = 1'b0;
         v.emit = 1'b1;
         if (hit >= 0) begin
            tab_dup[sel] = bump(tab_dup[sel]);
            v.emit = 1'b0;
         end else begin
            if (free_slot < 0) begin
               free_slot = tab_ptr[sel];
               tab_ptr[sel] = tab_ptr[sel] + 4'd1;
               tab_repl[sel] = bump(tab_repl[sel]);
               v.evicted = 1'b1;
            end
            tab_valid[sel][free_slot] = 1'b1;
            tab_h1[sel][free_slot] = run_h1;
            tab_h2[sel][free_slot] = run_h2;
         end
         v.dup = tab_dup[sel];
         v.repl = tab_repl[sel];
         verdict_q.push_back(v);
      end
      run_h1 = 64'd1469598103934665603;
      run_h2 = 64'd1099511628211;
      run_pos = '0;
   endtask

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            $error("result with no expectation waiting");
            errors++;
         end else begin
            e = verdict_q.pop_front();
            if (rsp_emit !== e.emit) begin
               $error("emit expected %0d actual %0d", e.emit, rsp_emit);
               errors++;
            end
            if (rsp_evicted !== e.evicted) begin
               $error("evicted expected %0d actual %0d", e.evicted, rsp_evicted);
               errors++;
            end
            if (rsp_duplicate_count !== e.dup) begin
               $error("duplicate_count expected %0d actual %0d", e.dup, rsp_duplicate_count);
               errors++;
            end
            if (rsp_replacement_count !== e.repl) begin
               $error("replacement_count expected %0d actual %0d", e.repl,
                      rsp_replacement_count);
               errors++;
            end
         end
      end
   end

   task automatic send_beat(logic cmd, logic [7:0] b, logic fs, logic last, logic [2:0] sel);
      if (idle_on && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 19)) @(negedge clock);
      req_command = cmd;
      req_data_byte = b;
      req_field_start = fs;
      req_record_last = last;
      req_table_select = sel;
      start = 1'b1;
      do @(posedge clock); while (busy);
      predict_beat(cmd, b, fs, last, sel);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_record(int len, logic [2:0] sel, int seed_byte);
      for (int i = 0; i < len; i++)
         send_beat(CMD_HASH, (seed_byte < 0) ? 8'($urandom) : 8'(seed_byte + i),
                   (i == 0) || ($urandom_range(0, 3) == 0), i == len - 1, sel);
   endtask

   task automatic drain();
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic test_directed();
      send_beat(CMD_HASH, 8'h00, 1'b1, 1'b1, 3'd0);
      send_beat(CMD_HASH, 8'h00, 1'b1, 1'b1, 3'd0);
      send_beat(CMD_HASH, 8'hFF, 1'b0, 1'b1, 3'd5);
      send_beat(CMD_HASH, 8'hFF, 1'b1, 1'b1, 3'd5);
      send_beat(CMD_HASH, 8'hA5, 1'b1, 1'b0, 3'd6);
      send_beat(CMD_HASH, 8'h5A, 1'b0, 1'b1, 3'd7);
      send_beat(CMD_HASH, 8'h12, 1'b1, 1'b0, 3'd7);
      send_beat(CMD_CLEAR, 8'hFF, 1'b1, 1'b1, 3'd7);
      send_beat(CMD_HASH, 8'h00, 1'b1, 1'b1, 3'd0);
      drain();
   endtask

   task automatic test_position_wrap();
      for (int i = 0; i < 300; i++)
         send_beat(CMD_HASH, 8'($urandom), i == 0, i == 299, 3'd2);
      send_record(1, 3'd2, 7);
      drain();
   endtask

   task automatic test_eviction();
      for (int r = 0; r < 40; r++) send_record(2, 3'd1, r);
      for (int r = 30; r < 40; r++) send_record(2, 3'd1, r);
      drain();
   endtask

   task automatic test_random();
      logic [2:0] sel;
      for (int n = 0; n < 450; n++) begin
         if (n > 380) idle_on = 1'b0;
         case ($urandom_range(0, 19))
            0: send_beat(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 3'($urandom));
            1: send_record($urandom_range(1, 3), 3'($urandom_range(6, 7)), -1);
            default: begin
               sel = 3'($urandom_range(0, 5));
               send_record($urandom_range(1, 3), sel,
                           ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 20)) : -1);
            end
         endcase
         if (n == 200) drain();
      end
      drain();
   endtask

   initial begin
      clear_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_position_wrap();
      test_eviction();
      test_random();
      if (errors == 0 && verdict_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #3ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
